@@ design/rpdaf_pkg.sv @@
// ----------------------------------------------------------------------------
// rpdaf_pkg
// Shared types and constants for the radio packet deframer / address filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpdaf_pkg;

    // Default largest accepted value of the length byte
    localparam int MAX_FRAME_LEN_DEF = 64;

    // Length byte counts these header bytes plus the payload
    localparam logic [7:0] HDR_LEN = 8'd4;

    // Broadcast destination address
    localparam logic [7:0] BCAST_ADDR = 8'hFF;

    // Configuration register indexes
    localparam logic [7:0] CFG_OWN_ADDR = 8'd0;
    localparam logic [7:0] CFG_PROMISC  = 8'd1;

    // Configuration reset values
    localparam logic [7:0] OWN_ADDR_RST = 8'hFF;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_BAD_LEN = 2'd2,
        KIND_BAD_ADR = 2'd3
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [5:0]  byte_index;
        logic        last;
        logic [7:0]  dest_header;
        logic [7:0]  source_header;
        logic [7:0]  id_header;
        logic [7:0]  flags_header;
        logic [15:0] good_frames;
    } result_t;

endpackage

`default_nettype wire

@@ design/radio_packet_deframer_addr_filter_unit.sv @@
// ----------------------------------------------------------------------------
// radio_packet_deframer_addr_filter_unit
// Receive deframer with length check and destination address filter.
//
// s_axis carries received FIFO bytes (tdata = rx_byte, tuser = frame_start).
// m_axis carries results: payload bytes with index, empty-frame completion
// and drop notices (tuser = kind, tlast = last), each with the captured
// header bytes and the good-frame count after that item.
// cfg writes own_address (index 0) and promiscuous (index 1); cfg_ready is
// always high. Write only while no item is in flight.
// An accepted item sits in the input register; once the output side has room
// it steps the frame state machine and its result, if any, loads into the
// output register, or into the skid stage while that register holds an item
// that is not taken. Throughput is one item per cycle while the output side has room.
// rst_n empties the input, output and skid registers, returns the parser to idle
// with headers and counter at zero, own_address to 0xFF and promiscuous to 0.
// A stalled receiver fills the output register and a skid stage; then the
// input register holds and s_axis_tready drops until space frees.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_packet_deframer_addr_filter_unit #(
    parameter int MAX_FRAME_LEN = rpdaf_pkg::MAX_FRAME_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] frame_start
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [7:0] data_byte, [13:8] byte_index,
                                             // [21:14] dest_header,
                                             // [29:22] source_header,
                                             // [37:30] id_header,
                                             // [45:38] flags_header,
                                             // [61:46] good_frames, [63:62] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast,
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import rpdaf_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic [7:0] own_address_reg;
    logic       promiscuous_reg;

    logic       step;
    logic       room;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign step          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || step;
    assign cfg_ready     = 1'b1;

    // Input register: hold an item until the output side has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= OWN_ADDR_RST;
            promiscuous_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OWN_ADDR: own_address_reg <= cfg_data;
                CFG_PROMISC:  promiscuous_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    rpdaf_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .own_address (own_address_reg),
        .promiscuous (promiscuous_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    rpdaf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result onto the stream
    assign m_axis_tdata = {2'b00, out_res.good_frames, out_res.flags_header,
                           out_res.id_header, out_res.source_header,
                           out_res.dest_header, out_res.byte_index, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

`ifndef SYNTHESIS
    // Skid stage only fills behind a valid output register
    assert property (@(posedge clk) disable iff (!rst_n) !room |-> m_axis_tvalid)
        else $error("skid stage full while output register empty");

    // Empty-frame completion always closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == KIND_EMPTY)) |-> res.last)
        else $error("empty-frame result without last");

    // Drop notices never close an accepted frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ((res.kind == KIND_BAD_LEN) || (res.kind == KIND_BAD_ADR))) |-> !res.last)
        else $error("drop result marked last");

    // A full output side stalls the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !room) |=> in_valid_reg)
        else $error("input item lost while output side full");
`endif

endmodule

`default_nettype wire

@@ design/rpdaf_parser.sv @@
// ----------------------------------------------------------------------------
// rpdaf_parser
// Frame state machine: length check, destination filter, header capture,
// payload indexing and good-frame count. Updates on each stepped item.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdaf_parser #(
    parameter int MAX_FRAME_LEN = rpdaf_pkg::MAX_FRAME_LEN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              frame_start,
    input  wire logic [7:0]        own_address,
    input  wire logic              promiscuous,
    output logic                   res_valid,
    output rpdaf_pkg::result_t     res
);
    import rpdaf_pkg::*;

    localparam logic [7:0] MaxLenByte = 8'(MAX_FRAME_LEN);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_DEST    = 6'b000010,
        PH_SRC     = 6'b000100,
        PH_ID      = 6'b001000,
        PH_FLAGS   = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [6:0]  remaining_reg, remaining_next;
    logic [5:0]  position_reg,  position_next;
    logic [7:0]  dest_reg,      dest_next;
    logic [7:0]  source_reg,    source_next;
    logic [7:0]  id_reg,        id_next;
    logic [7:0]  flags_reg,     flags_next;
    logic [15:0] good_reg,      good_next;

    logic        hit;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic        last;

    // Decode one item against the current phase
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        dest_next      = dest_reg;
        source_next    = source_reg;
        id_next        = id_reg;
        flags_next     = flags_reg;
        good_next      = good_reg;
        hit            = 1'b0;
        kind           = KIND_PAYLOAD;
        data_byte      = 8'd0;
        byte_index     = 6'd0;
        last           = 1'b0;

        if (frame_start)
        begin
            // Length byte: start a new frame or drop it
            if ((rx_byte < HDR_LEN) || (rx_byte > MaxLenByte))
            begin
                phase_next = PH_IDLE;
                hit        = 1'b1;
                kind       = KIND_BAD_LEN;
            end
            else
            begin
                remaining_next = 7'(rx_byte - HDR_LEN);
                position_next  = 6'd0;
                phase_next     = PH_DEST;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_DEST:
                begin
                    dest_next = rx_byte;
                    if (promiscuous || (rx_byte == own_address) || (rx_byte == BCAST_ADDR))
                    begin
                        phase_next = PH_SRC;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        hit        = 1'b1;
                        kind       = KIND_BAD_ADR;
                    end
                end
                PH_SRC:
                begin
                    source_next = rx_byte;
                    phase_next  = PH_ID;
                end
                PH_ID:
                begin
                    id_next    = rx_byte;
                    phase_next = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    flags_next = rx_byte;
                    if (remaining_reg == 7'd0)
                    begin
                        good_next  = good_reg + 16'd1;
                        phase_next = PH_IDLE;
                        hit        = 1'b1;
                        kind       = KIND_EMPTY;
                        last       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    hit            = 1'b1;
                    kind           = KIND_PAYLOAD;
                    data_byte      = rx_byte;
                    byte_index     = position_reg;
                    position_next  = position_reg + 6'd1;
                    remaining_next = remaining_reg - 7'd1;
                    if (remaining_reg <= 7'd1)
                    begin
                        last           = 1'b1;
                        good_next      = good_reg + 16'd1;
                        phase_next     = PH_IDLE;
                        remaining_next = 7'd0;
                    end
                end
                default:
                begin
                    // Idle: ignore stray bytes
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Advance state on each stepped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 7'd0;
            position_reg  <= 6'd0;
            dest_reg      <= 8'd0;
            source_reg    <= 8'd0;
            id_reg        <= 8'd0;
            flags_reg     <= 8'd0;
            good_reg      <= 16'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            dest_reg      <= dest_next;
            source_reg    <= source_next;
            id_reg        <= id_next;
            flags_reg     <= flags_next;
            good_reg      <= good_next;
        end
    end

    // Result shows the header registers as they stand after this item
    assign res_valid         = step && hit;
    assign res.kind          = kind;
    assign res.data_byte     = data_byte;
    assign res.byte_index    = byte_index;
    assign res.last          = last;
    assign res.dest_header   = dest_next;
    assign res.source_header = source_next;
    assign res.id_header     = id_next;
    assign res.flags_header  = flags_next;
    assign res.good_frames   = good_next;

endmodule

`default_nettype wire

@@ design/rpdaf_out_buf.sv @@
// ----------------------------------------------------------------------------
// rpdaf_out_buf
// Output register with a skid stage; room is a registered signal.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdaf_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rpdaf_pkg::result_t push_res,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rpdaf_pkg::result_t      out_res
);
    import rpdaf_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_res_reg;
    result_t skid_res_reg;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    // Control: fill the output register first, spill into the skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: move skid into output on pop, else load the new item
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_res_reg <= push_res;
            end
            else
            begin
                out_res_reg <= push_res;
            end
        end
    end

    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

@@ dv/deframer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte, result and register channels of the deframer, keeps its
// own model of the frame parser and address filter, and compares every
// result item field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module deframer_checker #(
    parameter int MAX_LEN = rpdaf_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          item_count,
    output int          result_count
);
    import rpdaf_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef enum logic [2:0] {
        AT_IDLE,
        AT_DEST,
        AT_SOURCE,
        AT_ID,
        AT_FLAGS,
        AT_PAYLOAD
    } parse_phase_t;

    // Model of the parser state and filter settings
    parse_phase_t parse_phase;
    logic [6:0]   bytes_left;
    logic [5:0]   payload_pos;
    logic [7:0]   dest_q;
    logic [7:0]   source_q;
    logic [7:0]   id_q;
    logic [7:0]   flags_q;
    logic [15:0]  good_q;
    logic [7:0]   own_addr_q;
    logic         promisc_q;

    result_t awaited_results[$];
    int      n_fail;
    int      n_items;
    int      n_results;

    // Advance the parser by one byte; report the result item it causes
    task automatic parse_rx_byte(input logic [7:0] rx, input logic start,
                                 output bit produced, output result_t res);
        produced = 1'b0;
        res = '0;
        if (start)
        begin
            if (rx < HDR_LEN || rx > MAX_LEN)
            begin
                parse_phase = AT_IDLE;
                produced = 1'b1;
                res.kind = KIND_BAD_LEN;
            end
            else
            begin
                bytes_left = 7'(rx - HDR_LEN);
                payload_pos = '0;
                parse_phase = AT_DEST;
            end
        end
        else
        begin
            case (parse_phase)
                AT_DEST:
                begin
                    dest_q = rx;
                    if (promisc_q || rx == own_addr_q || rx == BCAST_ADDR)
                        parse_phase = AT_SOURCE;
                    else
                    begin
                        parse_phase = AT_IDLE;
                        produced = 1'b1;
                        res.kind = KIND_BAD_ADR;
                    end
                end
                AT_SOURCE:
                begin
                    source_q = rx;
                    parse_phase = AT_ID;
                end
                AT_ID:
                begin
                    id_q = rx;
                    parse_phase = AT_FLAGS;
                end
                AT_FLAGS:
                begin
                    flags_q = rx;
                    if (bytes_left == 0)
                    begin
                        good_q = good_q + 16'd1;
                        parse_phase = AT_IDLE;
                        produced = 1'b1;
                        res.kind = KIND_EMPTY;
                        res.last = 1'b1;
                    end
                    else
                        parse_phase = AT_PAYLOAD;
                end
                AT_PAYLOAD:
                begin
                    produced = 1'b1;
                    res.kind = KIND_PAYLOAD;
                    res.data_byte = rx;
                    res.byte_index = payload_pos;
                    res.last = (bytes_left <= 1);
                    payload_pos = payload_pos + 6'd1;
                    bytes_left = bytes_left - 7'd1;
                    if (res.last)
                    begin
                        good_q = good_q + 16'd1;
                        parse_phase = AT_IDLE;
                        bytes_left = '0;
                    end
                end
                default:
                    parse_phase = AT_IDLE;
            endcase
        end
        // Header fields always show the registers after this byte
        res.dest_header = dest_q;
        res.source_header = source_q;
        res.id_header = id_q;
        res.flags_header = flags_q;
        res.good_frames = good_q;
    endtask

    task automatic compare_field(input string name, input logic [15:0] expv,
                                 input logic [15:0] actv);
        if (expv !== actv)
        begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bit      produced;
        result_t predicted;
        result_t oldest;
        if (!rst_n)
        begin
            parse_phase = AT_IDLE;
            bytes_left = '0;
            payload_pos = '0;
            dest_q = '0;
            source_q = '0;
            id_q = '0;
            flags_q = '0;
            good_q = '0;
            own_addr_q = OWN_ADDR_RST;
            promisc_q = 1'b0;
            awaited_results.delete();
            n_fail = 0;
            n_items = 0;
            n_results = 0;
        end
        else
        begin
            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OWN_ADDR: own_addr_q = cfg_data;
                    CFG_PROMISC:  promisc_q = cfg_data[0];
                    default: ;
                endcase
            end

            // Compare the result item against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (awaited_results.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $error("result item with none awaited: kind 0x%0h data 0x%0h",
                               m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    compare_field("kind", 16'(oldest.kind), 16'(m_axis_tuser));
                    compare_field("data_byte", 16'(oldest.data_byte),
                                  16'(m_axis_tdata[7:0]));
                    compare_field("byte_index", 16'(oldest.byte_index),
                                  16'(m_axis_tdata[13:8]));
                    compare_field("last", 16'(oldest.last), 16'(m_axis_tlast));
                    compare_field("dest_header", 16'(oldest.dest_header),
                                  16'(m_axis_tdata[21:14]));
                    compare_field("source_header", 16'(oldest.source_header),
                                  16'(m_axis_tdata[29:22]));
                    compare_field("id_header", 16'(oldest.id_header),
                                  16'(m_axis_tdata[37:30]));
                    compare_field("flags_header", 16'(oldest.flags_header),
                                  16'(m_axis_tdata[45:38]));
                    compare_field("good_frames", oldest.good_frames,
                                  m_axis_tdata[61:46]);
                end
            end

            // Predict from each accepted byte item
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_items++;
                parse_rx_byte(s_axis_tdata, s_axis_tuser, produced, predicted);
                if (produced)
                    awaited_results.push_back(predicted);
            end
        end
        fail_count <= n_fail;
        pending <= awaited_results.size();
        item_count <= n_items;
        result_count <= n_results;
    end

endmodule

@@ dv/radio_packet_deframer_addr_filter_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radio_packet_deframer_addr_filter_unit_tb
// Drives received bytes and filter settings into the deframer: a directed
// set of edge cases, random frames under several address settings, and a
// short full-rate run of empty frames. A checker beside the block predicts
// and compares all results.
// ----------------------------------------------------------------------------
module radio_packet_deframer_addr_filter_unit_tb;
    import rpdaf_pkg::*;

    localparam int MAX_LEN      = MAX_FRAME_LEN_DEF;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int FLOW_FRAMES  = 8;
    localparam int SETTLE       = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;

    int fail_count;
    int pending;
    int item_count;
    int result_count;

    int unsigned burst_left = 0;
    bit          steady_flow = 1'b0;
    int          phase_items;
    logic [7:0]  own_addr_now = OWN_ADDR_RST;

    radio_packet_deframer_addr_filter_unit #(
        .MAX_FRAME_LEN(MAX_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    deframer_checker #(
        .MAX_LEN(MAX_LEN)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .item_count    (item_count),
        .result_count  (result_count)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls: switch between steady, random, long-run and sparse patterns
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 400);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2:
            begin
                if (hold_left == 0)
                begin
                    m_axis_tready <= ~m_axis_tready;
                    hold_left <= $urandom_range(1, 20);
                end
                else
                    hold_left <= hold_left - 1;
            end
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Send one byte item; open a new burst after a random gap when one runs out
    task automatic send_item(input logic [7:0] rx, input logic start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (steady_flow || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rx;
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Hold the byte channel idle until every awaited result has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write both filter registers
    task automatic set_filter(input logic [7:0] addr, input logic promisc);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_OWN_ADDR;
        cfg_data <= addr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_PROMISC;
        cfg_data <= {7'd0, promisc};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        own_addr_now = addr;
    endtask

    // One random frame, a bad length, or stray bytes
    task automatic send_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned n_bytes;
        int unsigned roll;
        logic [7:0]  dest;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            // stray bytes with no frame start
            repeat ($urandom_range(1, 3))
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (pick < 14)
        begin
            // length byte outside the accepted window
            if (pick < 10)
                send_item(8'($urandom_range(0, HDR_LEN - 1)), 1'b1);
            else
                send_item(8'($urandom_range(MAX_LEN + 1, 255)), 1'b1);
            phase_items++;
        end
        else
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                len = MAX_LEN;
            else if (roll < 4)
                len = $urandom_range(HDR_LEN, MAX_LEN);
            else
                len = $urandom_range(HDR_LEN, 12);
            roll = $urandom_range(0, 99);
            if (roll < 45)
                dest = own_addr_now;
            else if (roll < 60)
                dest = BCAST_ADDR;
            else
                dest = 8'($urandom_range(0, 255));
            // cut a few frames short; the next frame start abandons them
            n_bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(0, len - 1) : len;
            send_item(8'(len), 1'b1);
            phase_items++;
            for (int i = 0; i < n_bytes; i++)
            begin
                send_item((i == 0) ? dest : 8'($urandom_range(0, 255)), 1'b0);
                phase_items++;
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stray byte after reset, then lengths below and above the window
        send_item(8'h00, 1'b0);
        send_item(8'h03, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'(MAX_LEN + 1), 1'b1);
        // Frame abandoned by a new frame start, then an empty broadcast frame
        send_item(8'd10, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h33, 1'b0);
        send_item(8'(HDR_LEN), 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        // Longest length with a rejected destination
        send_item(8'(MAX_LEN), 1'b1);
        send_item(8'h12, 1'b0);
        // Two payload bytes at the extremes, then a stray byte after completion
        send_item(8'd6, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h81, 1'b0);
        send_item(8'h7E, 1'b0);
        send_item(8'hC3, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h77, 1'b0);

        // Random frames under a sequence of filter settings
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                case (ph)
                    1: set_filter(8'h00, 1'b0);
                    2: set_filter(8'hFF, 1'b1);
                    3: set_filter(8'h00, 1'b1);
                    default: set_filter(8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)));
                endcase
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_frame();
        end

        // Empty broadcast frames back to back at full rate
        drain();
        set_filter(8'($urandom_range(0, 254)), 1'b0);
        steady_flow = 1'b1;
        for (int f = 0; f < FLOW_FRAMES; f++)
        begin
            send_item(8'(HDR_LEN), 1'b1);
            send_item(BCAST_ADDR, 1'b0);
            repeat (3)
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end

        drain();
        $display("Covered %0d byte items and %0d result items over %0d filter settings,",
                 item_count, result_count, N_PHASES + 1);
        $display("including drops, abandoned frames and back-to-back empty frames.");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
